// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/gwc_pkg.sv
// ---------------------------------------------------------------------------
// gwc_pkg
// Shared types and constants of the graph walk classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_SEQUENCE_DEF = 64;

    localparam int VERTEX_W   = 5;
    localparam int ROW_W      = 32;
    localparam int VC_W       = 6;
    localparam int EC_W       = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [EC_W-1:0] EC_MAX = 6'd63;

    // Input kind carried on tuser
    localparam logic ACT_ROW    = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Hits from one compare of a stored vertex against the newest vertex/edge
    typedef struct packed {
        logic vert_hit;
        logic inner_hit;
        logic edge_hit;
    } cmp_hit_t;

endpackage

// File: rtl/core/graph_walk_classifier_unit.sv
// ---------------------------------------------------------------------------
// graph_walk_classifier_unit
// Classifies a vertex sequence against a stored directed graph.
// ---------------------------------------------------------------------------
// Usage:
//   Input transfers on s_*: tuser 0 writes adjacency row tdata[36:5] at index
//   tdata[4:0]; tuser 1 appends vertex tdata[4:0] to the current sequence,
//   tlast marking its final vertex. cfg_we/cfg_wdata set the vertex count.
//   One result transfer on m_* follows each final vertex: six class flags,
//   the edge count and the overflow flag.
// Timing:
//   A row write is taken while the block is idle. A vertex stored after the
//   first starts a scan: the sequencer scans the earlier vertices through the
//   single store read port and the shared comparator, one per cycle, and
//   checks the new edge in the adjacency memory on the first scan cycle.
//   The final vertex then passes the emit state, which loads the result
//   register once it is free; the result shows on m_tvalid the cycle after.
//   Vertices dropped on overflow are taken without a scan.
// Reset:
//   Clears the sequence length and flags and the vertex count; the memories
//   are not cleared and hold no meaning until written.
// Stall:
//   The result register holds while m_tready is low; the block keeps taking
//   input until another result must be loaded, then waits for the register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_walk_classifier_unit #(
    parameter int MAX_VERTICES = gwc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_SEQUENCE = gwc_pkg::MAX_SEQUENCE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gwc_pkg::VC_W-1:0]           cfg_wdata,   // vertex_count
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gwc_pkg::IN_DATA_W-1:0]      s_tdata,     // vertex[4:0], row_bits[36:5]
    input  logic                               s_tuser,     // action
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // is_walk[0], is_trail[1], is_path[2], is_closed_walk[3], is_circuit[4],
    // is_simple_circuit[5], edge_count[11:6], overflow[12], zero pad[15:13]
    output logic [gwc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int ROWS = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int RAW  = $clog2(ROWS);
    localparam int SAW  = $clog2(MAX_SEQUENCE);
    localparam int LW   = $clog2(MAX_SEQUENCE + 1);
    localparam int CW   = LW + 7;

    gwc_pkg::state_t state_reg, state_next;

    logic [gwc_pkg::VC_W-1:0]      vcount_reg;
    logic [LW-1:0]                 len_reg;
    logic                          ovf_reg;
    logic                          walk_fail_reg;
    logic                          erep_reg;
    logic                          vrep_reg;
    logic                          inner_acc_reg;
    logic                          rep_k_reg;
    logic                          last_reg;
    logic [SAW-1:0]                cmp_idx_reg;
    logic [SAW-1:0]                cur_idx_reg;
    logic                          m_tvalid_reg;

    logic [gwc_pkg::VERTEX_W-1:0]  first_v_reg;
    logic [gwc_pkg::VERTEX_W-1:0]  prev_v_reg;
    logic [gwc_pkg::VERTEX_W-1:0]  cur_v_reg;
    logic [gwc_pkg::VERTEX_W-1:0]  prev_rd_reg;
    logic [gwc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [gwc_pkg::VERTEX_W-1:0]  in_v;
    logic [gwc_pkg::ROW_W-1:0]     in_row;
    logic                          in_xfer;
    logic                          vtx_xfer;
    logic                          room;
    logic                          store_xfer;
    logic                          scan_last;
    logic                          out_free;
    logic                          out_load;
    logic                          scan_step;
    logic                          row_we;
    logic [SAW-1:0]                seq_raddr;

    logic [gwc_pkg::ROW_W-1:0]     adj_row;
    logic [gwc_pkg::VERTEX_W-1:0]  seq_rdata;
    gwc_pkg::cmp_hit_t             hit;
    logic                          edge_ok;

    logic                          f_walk, f_trail, f_path, f_cw, f_circ, f_simp, f_closed;
    logic [CW-1:0]                 cnt_w;
    logic [gwc_pkg::EC_W-1:0]      ec;
    logic [gwc_pkg::OUT_DATA_W-1:0] result;

    // Decode the input transfer
    assign in_v       = s_tdata[gwc_pkg::VERTEX_W-1:0];
    assign in_row     = s_tdata[gwc_pkg::VERTEX_W +: gwc_pkg::ROW_W];
    assign in_xfer    = s_tvalid && s_tready;
    assign vtx_xfer   = in_xfer && (s_tuser == gwc_pkg::ACT_VERTEX);
    assign room       = (len_reg < LW'(MAX_SEQUENCE));
    assign store_xfer = vtx_xfer && room;
    assign scan_last  = (cmp_idx_reg == (cur_idx_reg - 1'b1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwc_pkg::ST_IDLE:
            begin
                if (vtx_xfer)
                begin
                    if (store_xfer && (len_reg != '0))
                    begin
                        state_next = gwc_pkg::ST_SCAN;
                    end
                    else if (s_tlast)
                    begin
                        state_next = gwc_pkg::ST_EMIT;
                    end
                end
            end
            gwc_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = last_reg ? gwc_pkg::ST_EMIT : gwc_pkg::ST_IDLE;
                end
            end
            gwc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = gwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gwc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        scan_step = 1'b0;
        out_load  = 1'b0;
        seq_raddr = '0;
        unique case (state_reg)
            gwc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            gwc_pkg::ST_SCAN:
            begin
                scan_step = 1'b1;
                seq_raddr = cmp_idx_reg + 1'b1;
            end
            gwc_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign row_we = in_xfer && (s_tuser == gwc_pkg::ACT_ROW) && (32'(in_v) < ROWS);

    gwc_adj_mem #(
        .ROWS (ROWS),
        .AW   (RAW)
    ) u_adj_mem (
        .clk   (clk),
        .we    (row_we),
        .waddr (in_v[RAW-1:0]),
        .wdata (in_row),
        .re    (store_xfer),
        .raddr (cur_v_reg[RAW-1:0]),
        .rdata (adj_row)
    );

    gwc_seq_mem #(
        .DEPTH (MAX_SEQUENCE),
        .AW    (SAW)
    ) u_seq_mem (
        .clk   (clk),
        .we    (store_xfer),
        .waddr (len_reg[SAW-1:0]),
        .wdata (in_v),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    gwc_cmp_unit u_cmp (
        .rd_vertex      (seq_rdata),
        .rd_prev_vertex (prev_rd_reg),
        .rd_not_first   (cmp_idx_reg != '0),
        .cur_vertex     (cur_v_reg),
        .prev_vertex    (prev_v_reg),
        .hit            (hit)
    );

    // Check the newest edge against the adjacency row and the vertex count
    assign edge_ok = ({1'b0, prev_v_reg} < vcount_reg) && ({1'b0, cur_v_reg} < vcount_reg)
                     && (32'(prev_v_reg) < ROWS) && adj_row[cur_v_reg];

    // Build the result item
    always_comb
    begin
        cnt_w    = CW'(len_reg) - 1'b1;
        ec       = (cnt_w > CW'(gwc_pkg::EC_MAX)) ? gwc_pkg::EC_MAX : cnt_w[gwc_pkg::EC_W-1:0];
        f_closed = (first_v_reg == cur_v_reg);
        f_walk   = !walk_fail_reg;
        f_trail  = f_walk && !erep_reg;
        f_path   = f_walk && !vrep_reg;
        f_cw     = f_walk && f_closed;
        f_circ   = f_cw && !erep_reg;
        f_simp   = f_cw && !inner_acc_reg;
        if (ovf_reg)
        begin
            result = {3'b000, 1'b1, gwc_pkg::EC_MAX, 6'b000000};
        end
        else
        begin
            result = {3'b000, 1'b0, ec, f_simp, f_circ, f_cw, f_path, f_trail, f_walk};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwc_pkg::ST_IDLE;
            vcount_reg    <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            walk_fail_reg <= 1'b0;
            erep_reg      <= 1'b0;
            vrep_reg      <= 1'b0;
            inner_acc_reg <= 1'b0;
            rep_k_reg     <= 1'b0;
            last_reg      <= 1'b0;
            cmp_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (vtx_xfer)
            begin
                last_reg <= s_tlast;
                if (!room)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            // Append: fold the previous vertex's interior repeat, restart the scan
            if (store_xfer)
            begin
                len_reg       <= len_reg + 1'b1;
                inner_acc_reg <= inner_acc_reg || rep_k_reg;
                rep_k_reg     <= 1'b0;
                cmp_idx_reg   <= '0;
            end
            // Advance the scan by one stored vertex
            if (scan_step)
            begin
                cmp_idx_reg <= cmp_idx_reg + 1'b1;
                if ((cmp_idx_reg == '0) && !edge_ok)
                begin
                    walk_fail_reg <= 1'b1;
                end
                erep_reg  <= erep_reg  || hit.edge_hit;
                vrep_reg  <= vrep_reg  || hit.vert_hit;
                rep_k_reg <= rep_k_reg || hit.inner_hit;
            end
            // Emit: start a fresh sequence
            if (out_load)
            begin
                len_reg       <= '0;
                ovf_reg       <= 1'b0;
                walk_fail_reg <= 1'b0;
                erep_reg      <= 1'b0;
                vrep_reg      <= 1'b0;
                inner_acc_reg <= 1'b0;
                rep_k_reg     <= 1'b0;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (store_xfer)
        begin
            cur_v_reg   <= in_v;
            prev_v_reg  <= cur_v_reg;
            cur_idx_reg <= len_reg[SAW-1:0];
            if (len_reg == '0)
            begin
                first_v_reg <= in_v;
            end
        end
        if (scan_step)
        begin
            prev_rd_reg <= seq_rdata;
        end
        if (out_load)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/gwc_adj_mem.sv
// ---------------------------------------------------------------------------
// gwc_adj_mem
// Adjacency row memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwc_adj_mem #(
    parameter int ROWS = 32,
    parameter int AW   = 5
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [gwc_pkg::ROW_W-1:0]   wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [gwc_pkg::ROW_W-1:0]   rdata
);

    logic [gwc_pkg::ROW_W-1:0] mem [ROWS];

    // Write a row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read a row, hold it until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/gwc_seq_mem.sv
// ---------------------------------------------------------------------------
// gwc_seq_mem
// Sequence vertex store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwc_seq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [gwc_pkg::VERTEX_W-1:0]   wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [gwc_pkg::VERTEX_W-1:0]   rdata
);

    logic [gwc_pkg::VERTEX_W-1:0] mem [DEPTH];

    // Store an appended vertex
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one stored vertex per cycle
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/gwc_cmp_unit.sv
// ---------------------------------------------------------------------------
// gwc_cmp_unit
// Shared compare unit: checks one stored vertex, and the stored edge that
// ends on it, against the newest vertex and the newest edge.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwc_cmp_unit (
    input  logic [gwc_pkg::VERTEX_W-1:0] rd_vertex,
    input  logic [gwc_pkg::VERTEX_W-1:0] rd_prev_vertex,
    input  logic                         rd_not_first,
    input  logic [gwc_pkg::VERTEX_W-1:0] cur_vertex,
    input  logic [gwc_pkg::VERTEX_W-1:0] prev_vertex,
    output gwc_pkg::cmp_hit_t            hit
);

    logic vert_eq;

    // Compare vertex and edge endpoints
    always_comb
    begin
        vert_eq       = (rd_vertex == cur_vertex);
        hit.vert_hit  = vert_eq;
        hit.inner_hit = vert_eq && rd_not_first;
        hit.edge_hit  = vert_eq && rd_not_first && (rd_prev_vertex == prev_vertex);
    end

endmodule

// File: rtl/core/gwc_checker.sv
// ---------------------------------------------------------------------------
// gwc_checker
// Port-level checks of the graph walk classifier, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gwc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gwc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Overflow result carries no flags and a saturated edge count
    `ASSERT_IMPLY(a_ovf_form, clk, rst_n, m_tvalid && m_tdata[12], m_tdata[11:0] == 12'hFC0)

    // Trail implies walk, circuit and simple circuit imply closed walk, closed walk implies walk
    `ASSERT_IMPLY(a_flag_order, clk, rst_n, m_tvalid,
                  (!m_tdata[1] || m_tdata[0]) && (!m_tdata[4] || m_tdata[3]) &&
                  (!m_tdata[3] || m_tdata[0]) && (!m_tdata[5] || m_tdata[3]))

    // A single vertex sequence reports every flag
    `ASSERT_IMPLY(a_single, clk, rst_n, m_tvalid && !m_tdata[12] && (m_tdata[11:6] == 6'd0),
                  m_tdata[5:0] == 6'h3F)

    // The final vertex of a sequence always takes the block busy
    `ASSERT_NEXT(a_busy_after_last, clk, rst_n,
                 s_tvalid && s_tready && (s_tuser == gwc_pkg::ACT_VERTEX) && s_tlast, !s_tready)

endmodule

bind graph_walk_classifier_unit gwc_checker u_gwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
